FILE: rtl/core/mscs_pkg.sv
// ----------------------------------------------------------------------------
// mscs_pkg
// Types, codes and the segment table shared by the marching squares core.
// ----------------------------------------------------------------------------
package mscs_pkg;

    localparam int CfgIndexBits = 2;
    localparam logic [CfgIndexBits-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CfgIndexBits-1:0] CFG_CELL_SIZE = 2'd1;

    localparam logic [21:0] COORD_MAX = 22'h3FFFFF;
    localparam logic [8:0]  FRAC_ONE  = 9'd256;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    typedef struct packed {
        logic [9:0]  cell_col;
        logic [9:0]  cell_row;
        logic [15:0] value_top_left;
        logic [15:0] value_top_right;
        logic [15:0] value_bottom_right;
        logic [15:0] value_bottom_left;
    } t_cell;

    typedef struct packed {
        logic [21:0] start_x;
        logic [21:0] start_y;
        logic [21:0] end_x;
        logic [21:0] end_y;
        logic [3:0]  case_code;
        logic        last_segment;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_edge      s0;
        t_edge      e0;
        t_edge      s1;
        t_edge      e1;
    } t_seg_plan;

    function automatic t_seg_plan seg_plan(input logic [3:0] code);
        t_seg_plan p;
        p = '{count: 2'd0, s0: EDGE_TOP, e0: EDGE_TOP, s1: EDGE_TOP, e1: EDGE_TOP};
        unique case (code)
            4'd1, 4'd14: begin
                p.count = 2'd1; p.s0 = EDGE_BOTTOM; p.e0 = EDGE_LEFT;
            end
            4'd2, 4'd13: begin
                p.count = 2'd1; p.s0 = EDGE_RIGHT; p.e0 = EDGE_BOTTOM;
            end
            4'd3, 4'd12: begin
                p.count = 2'd1; p.s0 = EDGE_RIGHT; p.e0 = EDGE_LEFT;
            end
            4'd4, 4'd11: begin
                p.count = 2'd1; p.s0 = EDGE_TOP; p.e0 = EDGE_RIGHT;
            end
            4'd5: begin
                p.count = 2'd2; p.s0 = EDGE_TOP; p.e0 = EDGE_LEFT;
                p.s1 = EDGE_RIGHT; p.e1 = EDGE_BOTTOM;
            end
            4'd6, 4'd9: begin
                p.count = 2'd1; p.s0 = EDGE_TOP; p.e0 = EDGE_BOTTOM;
            end
            4'd7, 4'd8: begin
                p.count = 2'd1; p.s0 = EDGE_TOP; p.e0 = EDGE_LEFT;
            end
            4'd10: begin
                p.count = 2'd2; p.s0 = EDGE_TOP; p.e0 = EDGE_RIGHT;
                p.s1 = EDGE_BOTTOM; p.e1 = EDGE_LEFT;
            end
            default: p.count = 2'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/mscs_div_lane.sv
// ----------------------------------------------------------------------------
// mscs_div_lane
// Edge interpolation fraction: operand prep stage, then a four stage
// restoring divider that retires two quotient bits per stage.
// ----------------------------------------------------------------------------
module mscs_div_lane (
    input  logic        i_clk,
    input  logic [15:0] i_thr,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [8:0]  o_frac
);
    import mscs_pkg::*;

    localparam int Stages = 4;

    logic signed [16:0] n_num;
    logic signed [16:0] n_dif;
    logic [15:0]        n_un;
    logic [15:0]        n_ud;
    logic               n_zero;

    logic [15:0] r_rem  [0:Stages];
    logic [15:0] r_den  [0:Stages];
    logic [7:0]  r_q    [0:Stages];
    logic        r_zero [0:Stages];
    logic        r_one  [0:Stages];

    always_comb begin
        n_num  = $signed({1'b0, i_thr}) - $signed({1'b0, i_a});
        n_dif  = $signed({1'b0, i_b}) - $signed({1'b0, i_a});
        n_un   = n_num[16] ? 16'(-n_num) : n_num[15:0];
        n_ud   = n_dif[16] ? 16'(-n_dif) : n_dif[15:0];
        n_zero = (n_dif == 17'sd0) || (n_num == 17'sd0) || (n_num[16] != n_dif[16]);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_un;
        r_den[0]  <= n_ud;
        r_q[0]    <= 8'd0;
        r_zero[0] <= n_zero;
        r_one[0]  <= !n_zero && (n_un >= n_ud);
    end

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        logic [16:0] n_r2a;
        logic [16:0] n_r2b;
        logic [15:0] n_rema;
        logic [15:0] n_remb;
        logic        n_ba;
        logic        n_bb;

        always_comb begin
            n_r2a  = {r_rem[k], 1'b0};
            n_ba   = n_r2a >= {1'b0, r_den[k]};
            n_rema = n_ba ? 16'(n_r2a - {1'b0, r_den[k]}) : n_r2a[15:0];
            n_r2b  = {n_rema, 1'b0};
            n_bb   = n_r2b >= {1'b0, r_den[k]};
            n_remb = n_bb ? 16'(n_r2b - {1'b0, r_den[k]}) : n_r2b[15:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_remb;
            r_den[k+1]  <= r_den[k];
            r_q[k+1]    <= {r_q[k][5:0], n_ba, n_bb};
            r_zero[k+1] <= r_zero[k];
            r_one[k+1]  <= r_one[k];
        end
    end

    // Remainder starts below the divisor, so eight steps give the whole quotient.
    assign o_frac = r_zero[Stages] ? 9'd0 :
                    r_one[Stages]  ? FRAC_ONE : {1'b0, r_q[Stages]};

endmodule

FILE: rtl/core/mscs_emit.sv
// ----------------------------------------------------------------------------
// mscs_emit
// Scales the edge fractions by the cell size, places the four crossing
// points and sequences up to two segment words onto the result port.
// ----------------------------------------------------------------------------
module mscs_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_cell_size,
    input  logic                    i_valid,
    input  logic [3:0]              i_code,
    input  logic [21:0]             i_ox,
    input  logic [21:0]             i_oy,
    input  logic [8:0]              i_frac [0:3],
    output logic                    o_valid,
    output mscs_pkg::t_result       o_result
);
    import mscs_pkg::*;

    logic        r_m_valid;
    logic [3:0]  r_m_code;
    logic [21:0] r_m_ox;
    logic [21:0] r_m_oy;
    logic [12:0] r_m_off [0:3];

    logic        r_valid;
    t_result     r_result;
    logic        r_pend_valid;
    t_result     r_pend;

    logic [21:0] n_ex [0:3];
    logic [21:0] n_ey [0:3];
    t_seg_plan   n_plan;
    logic [11:0] n_side;

    function automatic logic [21:0] sat_add(input logic [21:0] a, input logic [12:0] b);
        logic [22:0] s;
        s = {1'b0, a} + {10'd0, b};
        return s[22] ? COORD_MAX : s[21:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_code <= i_code;
        r_m_ox   <= i_ox;
        r_m_oy   <= i_oy;
        for (int k = 0; k < 4; k++) begin
            r_m_off[k] <= 13'((17'(i_cell_size) * 17'(i_frac[k])) >> 4);
        end
    end

    always_comb begin
        n_side = {i_cell_size, 4'd0};
        n_ex[EDGE_TOP]    = sat_add(r_m_ox, r_m_off[EDGE_TOP]);
        n_ey[EDGE_TOP]    = r_m_oy;
        n_ex[EDGE_RIGHT]  = sat_add(r_m_ox, {1'b0, n_side});
        n_ey[EDGE_RIGHT]  = sat_add(r_m_oy, r_m_off[EDGE_RIGHT]);
        n_ex[EDGE_BOTTOM] = sat_add(r_m_ox, r_m_off[EDGE_BOTTOM]);
        n_ey[EDGE_BOTTOM] = sat_add(r_m_oy, {1'b0, n_side});
        n_ex[EDGE_LEFT]   = r_m_ox;
        n_ey[EDGE_LEFT]   = sat_add(r_m_oy, r_m_off[EDGE_LEFT]);
        n_plan = seg_plan(r_m_code);
    end

    // Cells never arrive back to back, so the second word of a saddle
    // always finds the port free in the cycle after the first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_valid      <= (r_m_valid && n_plan.count != 2'd0) || r_pend_valid;
            r_pend_valid <= r_m_valid && n_plan.count == 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_valid) begin
            r_result <= r_pend;
        end else begin
            r_result <= '{start_x: n_ex[n_plan.s0], start_y: n_ey[n_plan.s0],
                          end_x: n_ex[n_plan.e0], end_y: n_ey[n_plan.e0],
                          case_code: r_m_code,
                          last_segment: n_plan.count == 2'd1};
        end
        r_pend <= '{start_x: n_ex[n_plan.s1], start_y: n_ey[n_plan.s1],
                    end_x: n_ex[n_plan.e1], end_y: n_ey[n_plan.e1],
                    case_code: r_m_code, last_segment: 1'b1};
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/core/marching_squares_cell_segments_core.sv
// Words pass the geometry and divider stages, the emit offset register and
// the result register; a saddle's second word follows in the next cycle.
// Cells overlap; busy follows each accept, and a start while busy is ignored.
// Reset: synchronous active low; threshold returns to 256, cell size to 10,
// and all pipeline valid bits clear. The receiver cannot stall.
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_core
// Classifies a grid cell against the iso level, interpolates its edge
// crossings and emits its contour segments in Q18.4 pixel coordinates.
// ----------------------------------------------------------------------------
module marching_squares_cell_segments_core #(
    parameter int INDEX_BITS = 10,
    parameter int VALUE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  mscs_pkg::t_cell                       i_cell,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mscs_pkg::CfgIndexBits-1:0]     i_cfg_index,
    input  logic [15:0]                           i_cfg_data,
    output logic                                  o_res_valid,
    output mscs_pkg::t_result                     o_res
);
    import mscs_pkg::*;

    localparam logic [9:0]  IMASK = (INDEX_BITS >= 10) ? 10'h3FF
                                  : 10'((1 << INDEX_BITS) - 1);
    localparam logic [15:0] VMAX  = (VALUE_BITS >= 16) ? 16'hFFFF
                                  : 16'((1 << VALUE_BITS) - 1);
    localparam int Depth = 5;

    logic [15:0] r_threshold;
    logic [7:0]  r_cell_size;
    logic        r_busy;

    logic        n_accept;
    logic [15:0] n_val [0:3];
    logic [3:0]  n_code;
    logic [21:0] n_ox;
    logic [21:0] n_oy;

    logic        r_v    [0:Depth-1];
    logic [3:0]  r_code [0:Depth-1];
    logic [21:0] r_ox   [0:Depth-1];
    logic [21:0] r_oy   [0:Depth-1];

    logic [8:0]  w_frac [0:3];

    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;
    assign n_accept    = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'd256;
            r_cell_size <= 8'd10;
            r_busy      <= 1'b0;
        end else begin
            r_busy <= n_accept;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_CELL_SIZE: r_cell_size <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_val[0] = (i_cell.value_top_left     > VMAX) ? VMAX : i_cell.value_top_left;
        n_val[1] = (i_cell.value_top_right    > VMAX) ? VMAX : i_cell.value_top_right;
        n_val[2] = (i_cell.value_bottom_right > VMAX) ? VMAX : i_cell.value_bottom_right;
        n_val[3] = (i_cell.value_bottom_left  > VMAX) ? VMAX : i_cell.value_bottom_left;
        n_code   = {n_val[0] >= r_threshold, n_val[1] >= r_threshold,
                    n_val[2] >= r_threshold, n_val[3] >= r_threshold};
        n_ox     = {18'(10'(i_cell.cell_col & IMASK) * r_cell_size), 4'd0};
        n_oy     = {18'(10'(i_cell.cell_row & IMASK) * r_cell_size), 4'd0};
    end

    // Cell geometry rides alongside the divider lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= n_accept;
            for (int k = 1; k < Depth; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code[0] <= n_code;
        r_ox[0]   <= n_ox;
        r_oy[0]   <= n_oy;
        for (int k = 1; k < Depth; k++) begin
            r_code[k] <= r_code[k-1];
            r_ox[k]   <= r_ox[k-1];
            r_oy[k]   <= r_oy[k-1];
        end
    end

    mscs_div_lane u_lane_top (
        .i_clk(i_clk), .i_thr(r_threshold), .i_a(n_val[0]), .i_b(n_val[1]),
        .o_frac(w_frac[EDGE_TOP])
    );
    mscs_div_lane u_lane_right (
        .i_clk(i_clk), .i_thr(r_threshold), .i_a(n_val[1]), .i_b(n_val[2]),
        .o_frac(w_frac[EDGE_RIGHT])
    );
    mscs_div_lane u_lane_bottom (
        .i_clk(i_clk), .i_thr(r_threshold), .i_a(n_val[3]), .i_b(n_val[2]),
        .o_frac(w_frac[EDGE_BOTTOM])
    );
    mscs_div_lane u_lane_left (
        .i_clk(i_clk), .i_thr(r_threshold), .i_a(n_val[0]), .i_b(n_val[3]),
        .o_frac(w_frac[EDGE_LEFT])
    );

    mscs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_size (r_cell_size),
        .i_valid     (r_v[Depth-1]),
        .i_code      (r_code[Depth-1]),
        .i_ox        (r_ox[Depth-1]),
        .i_oy        (r_oy[Depth-1]),
        .i_frac      (w_frac),
        .o_valid     (o_res_valid),
        .o_result    (o_res)
    );

endmodule
